### rtl/core/feeder_motor_step_controller_assert.svh
// Assertion macros for the feeder motor step controller.
// Each macro takes a label, clock, reset, an antecedent and a consequent.
`ifndef FEEDER_MOTOR_STEP_CONTROLLER_ASSERT_SVH
`define FEEDER_MOTOR_STEP_CONTROLLER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define FMSC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fmsc assertion failed");

// next-cycle implication
`define FMSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fmsc assertion failed");

`else

`define FMSC_ASSERT_NOW(label, clk, rst, ante, cons)
`define FMSC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### rtl/core/fmsc_pkg.sv
package fmsc_pkg;

  // command codes
  localparam logic [1:0] CMD_FEED   = 2'd0;
  localparam logic [1:0] CMD_SENSOR = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;

  // error codes
  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_CONFIG = 2'd1;
  localparam logic [1:0] ERR_BUSY   = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_FOUR_SENSOR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PART_PITCH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FEED_SPEED  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_DELAY  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_INVERT  = 3'd4;
  localparam int unsigned CFG_DATA_W = 16;

  // speed thresholds
  localparam logic [7:0] SLOW_SPEED_MIN  = 8'd128;
  localparam logic [7:0] HALVE_SPEED_MIN = 8'd96;

  typedef struct packed {
    logic [1:0] cmd;
    logic       ui_caused;
    logic       sensor_a;
    logic       sensor_b;
    logic       sensor_c;
    logic       sensor_d;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  pwm_duty;
    logic        motor_dir;
    logic        timer_start;
    logic        timer_stop;
    logic [15:0] timer_period;
    logic [1:0]  error_code;
    logic        part_used;
    logic        busy_res;
  } out_item_t;

  typedef struct packed {
    logic        four_sensor_mode;
    logic [7:0]  part_pitch;
    logic [7:0]  feed_speed;
    logic [15:0] slow_delay;
    logic        dir_invert;
  } cfg_t;

  typedef struct packed {
    logic [7:0] steps_left;
    logic [7:0] drive_speed;
    logic [1:0] sensor_phase;
    logic       feed_busy;
    logic [7:0] duty_out;
    logic       dir_out;
  } ctrl_state_t;

endpackage

### rtl/core/feeder_motor_step_controller.sv
// Channel   | Direction | Handshake          | Payload
// ----------+-----------+--------------------+---------------------------------
// in        | request   | in_valid/in_stall  | in_data: cmd, ui_caused, sensors
// out       | result    | out_valid/out_stall| out_data: duty, dir, timer, error
// cfg       | write     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Each request passes from acceptance into the input register, then through the
// decision logic into the output register. Throughput is one request per cycle
// while the result is not stalled; the single state update sets that figure.
// Reset (rst, synchronous) clears the state, the config registers and both valids.
// A stalled result holds the output register; the input register then holds too,
// and in_stall rises only when both registers are full.
`include "feeder_motor_step_controller_assert.svh"

module feeder_motor_step_controller (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  fmsc_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output fmsc_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fmsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fmsc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fmsc_pkg::*;

  cfg_t        cfg;
  ctrl_state_t state;
  ctrl_state_t state_next;
  in_item_t    in_q;
  logic        in_vld;
  out_item_t   result;
  logic        advance;
  logic        in_take;

  fmsc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fmsc_step_logic u_logic (
    .cfg        (cfg),
    .state      (state),
    .item       (in_q),
    .state_next (state_next),
    .result     (result)
  );

  // handshake
  assign advance  = in_vld && (!out_valid || !out_stall);
  assign in_stall = in_vld && !advance;
  assign in_take  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_take) begin
      in_vld <= 1'b1;
    end else if (advance) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) in_q <= in_data;
  end

  // controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_data <= result;
  end

  // checks
  `FMSC_ASSERT_NOW(a_busy_tracks_steps, clk, rst, 1'b1, state.feed_busy == (state.steps_left != 8'd0))
  `FMSC_ASSERT_NOW(a_used_means_started, clk, rst, out_valid && out_data.part_used, out_data.busy_res && out_data.error_code == ERR_NONE)
  `FMSC_ASSERT_NOW(a_timer_pulses_excl, clk, rst, out_valid, !(out_data.timer_start && out_data.timer_stop))
  `FMSC_ASSERT_NEXT(a_full_stall_holds, clk, rst, in_vld && out_valid && out_stall, in_vld && out_valid)

endmodule

### rtl/core/fmsc_cfg_regs.sv
module fmsc_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fmsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fmsc_pkg::CFG_DATA_W-1:0] cfg_data,
  output fmsc_pkg::cfg_t                  cfg
);
  import fmsc_pkg::*;

  // writes are always taken
  assign cfg_ready = 1'b1;

  // register file, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FOUR_SENSOR: cfg.four_sensor_mode <= cfg_data[0];
        REG_PART_PITCH:  cfg.part_pitch       <= cfg_data[7:0];
        REG_FEED_SPEED:  cfg.feed_speed       <= cfg_data[7:0];
        REG_SLOW_DELAY:  cfg.slow_delay       <= cfg_data[15:0];
        REG_DIR_INVERT:  cfg.dir_invert       <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/core/fmsc_step_logic.sv
module fmsc_step_logic (
  input  fmsc_pkg::cfg_t        cfg,
  input  fmsc_pkg::ctrl_state_t state,
  input  fmsc_pkg::in_item_t    item,
  output fmsc_pkg::ctrl_state_t state_next,
  output fmsc_pkg::out_item_t   result
);
  import fmsc_pkg::*;

  logic [7:0] count;
  logic       hit;
  logic [1:0] phase_hit;
  logic [7:0] steps_dec;
  logic       upd;
  logic       tstart;
  logic       tstop;
  logic       used;
  logic [1:0] err;

  // step count from pitch
  assign count = cfg.four_sensor_mode ? {1'b0, cfg.part_pitch[7:1]}
                                      : {2'b00, cfg.part_pitch[7:2]};

  // valid phase transition for a sensor event
  always_comb begin
    hit       = 1'b0;
    phase_hit = state.sensor_phase;
    if (cfg.four_sensor_mode) begin
      if (!item.sensor_a && item.sensor_b && !item.sensor_c && item.sensor_d
          && state.sensor_phase == 2'd0) begin
        hit = 1'b1; phase_hit = 2'd1;
      end else if (item.sensor_a && !item.sensor_b && !item.sensor_c && item.sensor_d
                   && state.sensor_phase == 2'd1) begin
        hit = 1'b1; phase_hit = 2'd2;
      end else if (item.sensor_a && !item.sensor_b && item.sensor_c && !item.sensor_d
                   && state.sensor_phase == 2'd2) begin
        hit = 1'b1; phase_hit = 2'd3;
      end else if (!item.sensor_a && item.sensor_b && item.sensor_c && !item.sensor_d
                   && state.sensor_phase == 2'd3) begin
        hit = 1'b1; phase_hit = 2'd0;
      end
    end else begin
      // single sensor: any nonzero phase acts as phase one
      if (item.sensor_a && state.sensor_phase == 2'd0) begin
        hit = 1'b1; phase_hit = 2'd1;
      end else if (!item.sensor_a && item.sensor_b && state.sensor_phase != 2'd0) begin
        hit = 1'b1; phase_hit = 2'd0;
      end
    end
  end

  assign upd       = hit && (state.steps_left != 8'd0);
  assign steps_dec = upd ? state.steps_left - 8'd1 : state.steps_left;

  // per-command state update
  always_comb begin
    state_next = state;
    tstart     = 1'b0;
    tstop      = 1'b0;
    used       = 1'b0;
    err        = ERR_NONE;
    unique case (item.cmd)
      CMD_FEED: begin
        if (cfg.feed_speed == 8'd0 || count == 8'd0) begin
          err = ERR_CONFIG;
        end else if (state.steps_left > 8'd1 || state.feed_busy) begin
          if (!item.ui_caused) err = ERR_BUSY;
        end else begin
          state_next.feed_busy   = 1'b1;
          state_next.steps_left  = count;
          state_next.duty_out    = cfg.feed_speed;
          state_next.dir_out     = ~cfg.dir_invert;
          state_next.drive_speed = cfg.feed_speed;
          if (cfg.four_sensor_mode) begin
            state_next.sensor_phase = {item.sensor_a, item.sensor_a ^ item.sensor_d};
          end else begin
            state_next.sensor_phase = {1'b0, item.sensor_a};
          end
          used   = 1'b1;
          tstart = (cfg.feed_speed >= SLOW_SPEED_MIN) && (count == 8'd1)
                   && (cfg.slow_delay != 16'd0);
        end
      end
      CMD_SENSOR: begin
        if (state.steps_left != 8'd0 || state.feed_busy) begin
          if (hit) begin
            state_next.steps_left   = steps_dec;
            state_next.sensor_phase = phase_hit;
          end
          tstart = (steps_dec == 8'd1) && upd && (cfg.slow_delay != 16'd0);
          if (steps_dec == 8'd0) begin
            state_next.duty_out  = 8'd0;
            state_next.dir_out   = cfg.dir_invert;
            state_next.feed_busy = 1'b0;
            tstop = 1'b1;
          end
        end
      end
      CMD_TICK: begin
        if (state.steps_left != 8'd0 && state.drive_speed >= HALVE_SPEED_MIN
            && state.feed_busy) begin
          state_next.drive_speed = {1'b0, state.drive_speed[7:1]};
          state_next.duty_out    = {1'b0, state.drive_speed[7:1]};
          state_next.dir_out     = ~cfg.dir_invert;
          tstart = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // result item
  always_comb begin
    result.pwm_duty     = state_next.duty_out;
    result.motor_dir    = state_next.dir_out;
    result.timer_start  = tstart;
    result.timer_stop   = tstop;
    result.timer_period = cfg.slow_delay;
    result.error_code   = err;
    result.part_used    = used;
    result.busy_res     = state_next.feed_busy;
  end

endmodule
